[rtl/core/afadc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afadc_pkg: shared constants for the API frame ADC receiver
// Field widths, register indexes and the fixed-point temperature constants.
// ----------------------------------------------------------------------------
package afadc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxLenW = 16;
  localparam int unsigned LeftW   = 17;
  localparam int unsigned AdcW    = 16;
  localparam int unsigned TempW   = 21;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned OutW    = 40;   // adc + temp, padded to whole bytes

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_SOF_BYTE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_TYPE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH = 2'd2;

  localparam logic [ByteW-1:0]   SOF_BYTE_RST   = 8'h7E;
  localparam logic [ByteW-1:0]   FRAME_TYPE_RST = 8'h92;
  localparam logic [MaxLenW-1:0] MAX_LENGTH_RST = 16'd49;
  localparam logic [MaxLenW-1:0] MIN_LENGTH     = 16'd3;
  localparam logic [ByteW-1:0]   GOOD_SUM       = 8'hFF;

  // temp = floor((adc*12500 + 511) / 1023) - 5000
  localparam int unsigned ProdW = 30;    // adc*12500+511 < 2^30
  localparam int unsigned QuoW  = 20;    // quotient < 2^20
  localparam int unsigned RemW  = 31;
  localparam int unsigned RecipShift = 40;
  localparam int unsigned RecipW     = 31;
  localparam int unsigned WideW      = ProdW + RecipW;
  localparam logic [ProdW-1:0]  ADC_GAIN    = 30'd12500;
  localparam logic [ProdW-1:0]  ADC_ROUND   = 30'd511;
  localparam logic [RemW-1:0]   ADC_DIV     = 31'd1023;
  // (2^40 - 1) / 1023, exact; the estimate is the quotient or one below it
  localparam logic [RecipW-1:0] ADC_RECIP   = 31'd1074791425;
  localparam logic [TempW-1:0]  TEMP_OFFSET = 21'd5000;

endpackage

[rtl/core/api_frame_adc_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_adc_receiver: API frame parser giving ADC sample and temperature
// Hunts for the start byte, checks length, type and checksum, and converts
// the last two data bytes of a good frame into a temperature in 0.01 degC.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer, and a byte can be accepted in
// every clock cycle while the slave side is not stalled. The frame parser
// updates its state in the cycle a byte is accepted; a good frame's sample
// then passes a four-register pipeline (parse result, scale multiply,
// reciprocal multiply, quotient correction) before it appears on the master
// side. Each stage holds its item until the next one frees up, so the slave
// side stalls only when every stage is full and the output is not taken.
// Registers may be written at any time and take effect on the next byte.
module api_frame_adc_receiver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [afadc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [afadc_pkg::CfgW-1:0]        cfg_data_i,
  // received bytes
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [afadc_pkg::ByteW-1:0]       s_axis_tdata_i,  // [7:0] rx_byte
  // results
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [15:0] adc_value, [36:16] temp_centi (signed), [39:37] zero
  output logic [afadc_pkg::OutW-1:0]        m_axis_tdata_o
);

  import afadc_pkg::*;

  typedef enum logic [1:0] {PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_BODY} phase_e;

  // configuration registers
  logic [ByteW-1:0]   sof_byte_q;
  logic [ByteW-1:0]   frame_type_q;
  logic [MaxLenW-1:0] max_length_q;

  // parser state
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] len_hi_q, len_hi_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] older_q, older_d;
  logic [ByteW-1:0] newer_q, newer_d;
  logic             type_pend_q, type_pend_d;
  logic             good;

  // pipeline
  logic             v1_q, v2_q, v3_q, v4_q;
  logic             rdy1, rdy2, rdy3, rdy4;
  logic [AdcW-1:0]  adc1_q, adc2_q, adc3_q, adc4_q;
  logic [ProdW-1:0] p2_q, p3_q;
  logic [QuoW-1:0]  qe3_q;
  logic [TempW-1:0] temp4_q;

  logic             s_fire;
  logic [ByteW-1:0] b;
  logic [MaxLenW-1:0] len;
  logic [WideW-1:0] wide;
  logic [RemW-1:0]  rem;
  logic [QuoW-1:0]  quo;

  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;
  assign s_fire = s_axis_tvalid_i && rdy1;
  assign b = s_axis_tdata_i;
  assign len = {len_hi_q, b};

  always_comb begin
    phase_d     = phase_q;
    len_hi_d    = len_hi_q;
    left_d      = left_q;
    sum_d       = sum_q;
    type_d      = type_q;
    older_d     = older_q;
    newer_d     = newer_q;
    type_pend_d = type_pend_q;
    good        = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (b == sof_byte_q) phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_hi_d = b;
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (len > max_length_q || len < MIN_LENGTH) begin
          phase_d = PH_HUNT;
        end else begin
          left_d      = LeftW'(len) + LeftW'(1);
          sum_d       = '0;
          type_pend_d = 1'b1;
          phase_d     = PH_BODY;
        end
      end
      PH_BODY: begin
        sum_d = sum_q + b;
        if (left_q > LeftW'(1)) begin
          left_d = left_q - LeftW'(1);
          if (type_pend_q) begin
            type_d      = b;
            type_pend_d = 1'b0;
          end else begin
            older_d = newer_q;
            newer_d = b;
          end
        end else begin
          // checksum byte
          left_d      = '0;
          phase_d     = PH_HUNT;
          type_pend_d = 1'b0;
          good        = (sum_d == GOOD_SUM) && (type_q == frame_type_q);
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_byte_q   <= SOF_BYTE_RST;
      frame_type_q <= FRAME_TYPE_RST;
      max_length_q <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SOF_BYTE:   sof_byte_q   <= cfg_data_i[ByteW-1:0];
        REG_FRAME_TYPE: frame_type_q <= cfg_data_i[ByteW-1:0];
        REG_MAX_LENGTH: max_length_q <= cfg_data_i[MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      len_hi_q    <= '0;
      left_q      <= '0;
      sum_q       <= '0;
      type_q      <= '0;
      older_q     <= '0;
      newer_q     <= '0;
      type_pend_q <= 1'b0;
    end else if (s_fire) begin
      phase_q     <= phase_d;
      len_hi_q    <= len_hi_d;
      left_q      <= left_d;
      sum_q       <= sum_d;
      type_q      <= type_d;
      older_q     <= older_d;
      newer_q     <= newer_d;
      type_pend_q <= type_pend_d;
    end
  end

  // quotient estimate from the reciprocal product, then one correction step
  assign wide = WideW'(p2_q) * WideW'(ADC_RECIP);
  assign rem  = RemW'(p3_q) - ((RemW'(qe3_q) << 10) - RemW'(qe3_q));
  assign quo  = (rem >= ADC_DIV) ? qe3_q + QuoW'(1) : qe3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_fire && good;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) adc1_q <= {older_q, newer_q};
    if (rdy2) begin
      adc2_q <= adc1_q;
      p2_q   <= ProdW'(adc1_q) * ADC_GAIN + ADC_ROUND;
    end
    if (rdy3) begin
      adc3_q <= adc2_q;
      p3_q   <= p2_q;
      qe3_q  <= wide[RecipShift +: QuoW];
    end
    if (rdy4) begin
      adc4_q  <= adc3_q;
      temp4_q <= TempW'(quo) - TEMP_OFFSET;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {{(OutW - TempW - AdcW){1'b0}}, temp4_q, adc4_q};

  // the input only stalls behind a full, untaken output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back-pressure");

  // a frame body always has at least the checksum byte outstanding
  a_body_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (left_q != '0))
    else $error("body phase with no bytes left");

  // temperature never below the offset floor
  a_temp_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(temp4_q) >= -$signed(TEMP_OFFSET)))
    else $error("temperature below lower bound");

  // quotient correction leaves a proper remainder
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (rem < (ADC_DIV << 1)))
    else $error("reciprocal estimate off by more than one");

endmodule

[test/api_frame_adc_receiver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_adc_receiver_tb: self-checking bench for the API frame ADC receiver
// Streams framed and broken byte sequences under random flow control, predicts
// each ADC sample and temperature in a scoreboard and compares every result.
// ----------------------------------------------------------------------------
module api_frame_adc_receiver_tb;
  import afadc_pkg::*;

  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 10;   // pipeline is four stages deep
  localparam int unsigned MaxReports  = 10;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY
  } parse_phase_e;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_ZEROS,
    FILL_ONES
  } data_fill_e;

  // Mirror of the frame parser plus the queue of samples it should emit
  class adc_frame_scoreboard;
    logic [ByteW-1:0]   sof_byte;
    logic [ByteW-1:0]   frame_type;
    logic [MaxLenW-1:0] max_length;
    parse_phase_e       phase;
    logic [ByteW-1:0]   len_high;
    logic [LeftW-1:0]   body_left;
    logic [ByteW-1:0]   body_sum;
    logic [ByteW-1:0]   type_seen;
    logic [ByteW-1:0]   older_data;
    logic [ByteW-1:0]   newer_data;
    logic               type_wait;
    logic [OutW-1:0]    sample_q[$];
    int unsigned        errors;
    int unsigned        results_checked;

    function new();
      sof_byte        = SOF_BYTE_RST;
      frame_type      = FRAME_TYPE_RST;
      max_length      = MAX_LENGTH_RST;
      phase           = PH_HUNT;
      len_high        = '0;
      body_left       = '0;
      body_sum        = '0;
      type_seen       = '0;
      older_data      = '0;
      newer_data      = '0;
      type_wait       = 1'b0;
      errors          = 0;
      results_checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_SOF_BYTE:   sof_byte   = data[ByteW-1:0];
        REG_FRAME_TYPE: frame_type = data[ByteW-1:0];
        REG_MAX_LENGTH: max_length = data[MaxLenW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return sample_q.size();
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      logic [LeftW-1:0] len;
      int unsigned      adc_val;
      int unsigned      quo;
      logic [TempW-1:0] temp;
      case (phase)
        PH_HUNT: if (b == sof_byte) phase = PH_LEN_HI;
        PH_LEN_HI: begin
          len_high = b;
          phase    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len = {1'b0, len_high, b};
          if (len > max_length || len < MIN_LENGTH) begin
            phase = PH_HUNT;
          end else begin
            body_left = len + 1'b1;
            body_sum  = '0;
            type_wait = 1'b1;
            phase     = PH_BODY;
          end
        end
        default: begin
          body_sum = body_sum + b;
          if (body_left > 1) begin
            body_left = body_left - 1'b1;
            if (type_wait) begin
              type_seen = b;
              type_wait = 1'b0;
            end else begin
              older_data = newer_data;
              newer_data = b;
            end
          end else begin
            // checksum byte closes the frame either way
            body_left = '0;
            type_wait = 1'b0;
            phase     = PH_HUNT;
            if (body_sum == GOOD_SUM && type_seen == frame_type) begin
              adc_val = 32'({older_data, newer_data});
              quo     = (adc_val * 12500 + 511) / 1023;
              temp    = TempW'(quo - 5000);
              sample_q.push_back({3'b000, temp, older_data, newer_data});
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [OutW-1:0] got);
      logic [OutW-1:0] want;
      results_checked++;
      if (sample_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("ERROR: result with none expected: adc %h temp %h pad %h",
                   got[15:0], got[36:16], got[39:37]);
        return;
      end
      want = sample_q.pop_front();
      if (got[15:0] !== want[15:0] || got[36:16] !== want[36:16] ||
          got[39:37] !== want[39:37]) begin
        errors++;
        if (errors <= MaxReports)
          $display("ERROR: adc exp %h got %h, temp exp %0d got %0d, pad exp %h got %h",
                   want[15:0], got[15:0], $signed(want[36:16]), $signed(got[36:16]),
                   want[39:37], got[39:37]);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [ByteW-1:0]    s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutW-1:0]     m_axis_tdata_o;

  adc_frame_scoreboard sb;
  logic                send_fast;
  logic                recv_fast;
  logic                frame_burst;
  logic                hold_req;
  int unsigned         frame_bytes;
  int unsigned         frames_sent;

  api_frame_adc_receiver u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] rx_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)    // [15:0] adc, [36:16] temp, [39:37] 0
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    send_fast       = 1'b0;
    recv_fast       = 1'b0;
    frame_burst     = 1'b0;
    hold_req        = 1'b0;
    frame_bytes     = 0;
    frames_sent     = 0;
  end

  // Transfers are sampled on the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_byte(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    end
  end

  // Result sink: random stalls per result, one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    bit          hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      gap = recv_fast ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    @(posedge rst_ni);
    repeat (LimitCycles) @(posedge clk_i);
    $display("Run stopped at the cycle limit with %0d samples outstanding", sb.pending());
    $display("Mismatches found");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [ByteW-1:0] b, input bit counted);
    int unsigned gap;
    gap = (send_fast || frame_burst) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    if (counted) frame_bytes++;
  endtask

  task automatic send_header(input int unsigned len);
    frame_burst = ($urandom_range(0, 4) == 0);
    frames_sent++;
    send_byte(sb.sof_byte, 1'b1);
    send_byte(len[15:8], 1'b1);
    send_byte(len[7:0], 1'b1);
  endtask

  // type byte, len-1 data bytes, then the checksum (optionally spoilt)
  task automatic send_frame(input int unsigned len, input logic [ByteW-1:0] type_byte,
                            input logic [ByteW-1:0] sum_flip, input data_fill_e fill);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] d;
    send_header(len);
    send_byte(type_byte, 1'b1);
    sum = type_byte;
    for (int unsigned i = 1; i < len; i++) begin
      case (fill)
        FILL_ZEROS: d = 8'h00;
        FILL_ONES:  d = 8'hFF;
        default:    d = 8'($urandom_range(0, 255));
      endcase
      sum = sum + d;
      send_byte(d, 1'b1);
    end
    send_byte((GOOD_SUM - sum) ^ sum_flip, 1'b1);
  endtask

  function automatic int unsigned pick_len();
    int unsigned top;
    top = (sb.max_length < 12) ? 32'(sb.max_length) : 12;
    if ($urandom_range(0, 19) == 0) top = (sb.max_length < 60) ? 32'(sb.max_length) : 60;
    return $urandom_range(3, top);
  endfunction

  task automatic random_frame();
    int unsigned      pick;
    int unsigned      len;
    logic [ByteW-1:0] flip;
    pick = $urandom_range(0, 99);
    flip = 8'($urandom_range(1, 255));
    if (pick < 65) begin
      send_frame(pick_len(), sb.frame_type, 8'h00,
                 ($urandom_range(0, 15) == 0) ? FILL_ONES : FILL_RANDOM);
    end else if (pick < 75) begin
      send_frame(pick_len(), sb.frame_type, flip, FILL_RANDOM);
    end else if (pick < 83) begin
      send_frame(pick_len(), sb.frame_type ^ flip, 8'h00, FILL_RANDOM);
    end else if (pick < 89 && sb.max_length < 16'hFFFF) begin
      len = $urandom_range(0, 1) ? sb.max_length + 1
                                 : $urandom_range(sb.max_length + 1, 65535);
      send_header(len);
    end else if (pick < 94) begin
      send_header($urandom_range(0, 2));
    end else begin
      // stray bytes, possibly a truncated frame start
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = frame_bytes + count;
    while (frame_bytes < stop_at) random_frame();
    s_axis_tvalid_i = 1'b0;
  endtask

  // Wait for every sample to drain, plus margin for a frame still in flight
  task automatic quiesce();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic configure(input logic [ByteW-1:0] start_b, input logic [ByteW-1:0] type_b,
                           input logic [MaxLenW-1:0] max_len);
    logic [CfgIdxW-1:0] idx_list [4];
    logic [CfgW-1:0]    val_list [4];
    idx_list = '{REG_SOF_BYTE, REG_FRAME_TYPE, REG_MAX_LENGTH, REG_UNUSED};
    val_list[0] = {8'($urandom_range(0, 255)), start_b};   // upper bits ignored
    val_list[1] = {8'($urandom_range(0, 255)), type_b};
    val_list[2] = max_len;
    val_list[3] = 16'($urandom_range(0, 65535));
    quiesce();
    cfg_we_i = 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_idx_i  = idx_list[i];
      cfg_data_i = val_list[i];
      @(negedge clk_i);
      sb.write_reg(idx_list[i], val_list[i]);
    end
    cfg_we_i = 1'b0;
  endtask

  initial begin : stimulus
    #0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset settings, sample extremes and the rejection paths
    send_frame(3, sb.frame_type, 8'h00, FILL_ZEROS);
    send_frame(3, sb.frame_type, 8'h00, FILL_ONES);
    send_header(sb.max_length + 1);             // oversize length
    send_header(2);                             // short length
    send_frame(3, sb.sof_byte, 8'h00, FILL_RANDOM);   // start byte as type, wrong type
    s_axis_tvalid_i = 1'b0;
    run_random(40);

    // Lowest bounds, plus a long output hold-off while frames keep coming
    configure(8'h00, 8'hFF, MIN_LENGTH);
    hold_req  = 1'b1;
    send_fast = 1'b1;
    repeat (12) send_frame(3, sb.frame_type, 8'h00, FILL_RANDOM);
    send_fast = 1'b0;
    run_random(35);

    // Highest bounds and a frame with a two-byte length
    configure(8'hFF, 8'h00, 16'hFFFF);
    send_frame(256, sb.frame_type, 8'h00, FILL_RANDOM);
    run_random(35);

    // Random settings with no idling on either side
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              16'($urandom_range(3, 80)));
    send_fast = 1'b1;
    recv_fast = 1'b1;
    run_random(35);
    send_fast = 1'b0;
    recv_fast = 1'b0;

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              ($urandom_range(0, 3) == 0) ? 16'($urandom_range(3, 65535))
                                          : 16'($urandom_range(3, 40)));
    run_random(35);

    quiesce();
    $display("Sent %0d frame bytes in %0d frames over five register settings",
             frame_bytes, frames_sent);
    $display("%0d results checked across good, oversize, short, wrong-type and",
             sb.results_checked);
    $display("bad-checksum frames, stray bytes, a long frame and an output hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d samples outstanding", sb.errors, sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
